/* rtl/kerl_pkg.sv */
// Package for the keyed event rate limiter: types and constants shared by
// the cell, the cell-address converter and the top level. No dependencies.
`default_nettype none
package kerl_pkg;

    localparam int POS_W   = 24;
    localparam int CELL_W  = 18;
    localparam int TIME_W  = 32;
    localparam int ASSET_W = 16;
    localparam int IV_W    = 16;
    localparam int CNT_W   = 7;

    localparam logic OP_PLAY  = 1'b0;
    localparam logic OP_SWEEP = 1'b1;

    // Record carried along the chain of cells.
    typedef struct packed {
        logic                     valid;
        logic                     kind;
        logic [ASSET_W-1:0]       asset;
        logic signed [CELL_W-1:0] cx;
        logic signed [CELL_W-1:0] cy;
        logic signed [CELL_W-1:0] cz;
        logic [TIME_W-1:0]        last;
    } t_rec;

endpackage
`default_nettype wire

/* rtl/kerl_cell_conv.sv */
// Converts one signed world coordinate to a cell index, floor((p+50)/100),
// with a two-stage reciprocal multiply. Uses kerl_pkg.
`default_nettype none
module kerl_cell_conv (
    input  wire logic                              i_clk,
    input  wire logic signed [kerl_pkg::POS_W-1:0] i_pos,
    output logic signed [kerl_pkg::CELL_W-1:0]     o_cell
);
    import kerl_pkg::*;

    // v = pos + 50 + 100*167772 is always positive and below 2^25; the offset
    // is a whole number of cells, so floor(v/100) - 167772 is the cell.
    localparam logic [25:0] BIAS  = 26'd16777250;
    localparam logic [25:0] OFFS  = 26'd167772;
    // ceil(2^32/100): the excess stays far below 1/100 for v < 2^25, so the
    // truncated product is already the exact quotient
    localparam logic [25:0] RECIP = 26'd42949673;

    logic [25:0] v;
    logic [51:0] prod;
    logic [25:0] r_v;
    logic [25:0] r_q;
    logic [25:0] cell_off;

    assign v    = {{2{i_pos[POS_W-1]}}, i_pos} + BIAS;
    assign prod = 52'(r_v) * 52'(RECIP);

    always_ff @(posedge i_clk) begin
        r_v <= v;
        r_q <= 26'(prod[51:32]);
    end

    assign cell_off = r_q - OFFS;
    assign o_cell   = signed'(cell_off[CELL_W-1:0]);
endmodule
`default_nettype wire

/* rtl/kerl_cell.sv */
// One cell of the record chain: holds a record and takes the next one in
// when shift is high; reset clears only its valid bit. Uses kerl_pkg.
`default_nettype none
module kerl_cell (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_shift,
    input  wire kerl_pkg::t_rec                   i_rec,
    output kerl_pkg::t_rec                        o_rec
);
    import kerl_pkg::*;

    logic r_valid;
    t_rec r_rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_rec.valid;
        end
        if (i_shift) begin
            r_rec <= i_rec;
        end
    end

    always_comb begin
        o_rec       = r_rec;
        o_rec.valid = r_valid;
    end
endmodule
`default_nettype wire

/* rtl/keyed_event_rate_limiter.sv */
// Keyed event rate limiter: records live in a circular chain of ENTRIES
// cells that rotates by one each cycle during the scan and write-back
// laps. A play request goes through cell conversion, a lap of ENTRIES
// records that finds the hit and the lowest free entry, a second lap that
// writes back, the load of the output register and a return to idle. A
// sweep needs one lap, which drops expired records, before the output load.
// A result still held by a stalled output delays the load of the next and
// so the accept of the request after it.
// One request is handled at a time; inserts take the lowest free entry.
`default_nettype none
module keyed_event_rate_limiter #(
    parameter int ENTRIES = 64
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [15:0]                        i_cfg_wdata,
    input  wire logic                               i_valid,
    output logic                                    o_stall,
    input  wire logic                               i_operation,
    input  wire logic                               i_kind,
    input  wire logic [kerl_pkg::ASSET_W-1:0]       i_asset_id,
    input  wire logic signed [kerl_pkg::POS_W-1:0]  i_pos_x,
    input  wire logic signed [kerl_pkg::POS_W-1:0]  i_pos_y,
    input  wire logic signed [kerl_pkg::POS_W-1:0]  i_pos_z,
    input  wire logic [kerl_pkg::TIME_W-1:0]        i_now_ms,
    input  wire logic [kerl_pkg::IV_W-1:0]          i_min_interval,
    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output logic                                    o_allowed,
    output logic                                    o_table_full,
    output logic [kerl_pkg::CNT_W-1:0]              o_removed_count
);
    import kerl_pkg::*;

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CONV = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_WB   = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]  r_state;
    logic [1:0]  r_wait;
    logic [15:0] r_expiry;
    logic [CW-1:0] r_cnt;
    logic        r_op, r_kind;
    logic [ASSET_W-1:0] r_asset;
    logic [TIME_W-1:0]  r_now;
    logic [IV_W-1:0]    r_iv;
    logic signed [CELL_W-1:0] cx, cy, cz;
    logic        r_hit, r_free;
    logic [IW-1:0] r_hit_idx, r_free_idx;
    logic [CNT_W-1:0] r_removed;
    logic        r_allowed, r_full, r_ovalid;
    logic        r_out_allowed, r_out_full;
    logic [CNT_W-1:0] r_out_removed;

    t_rec chain [ENTRIES];
    t_rec head, feed;
    logic shift;

    // hold the position for the converters while the request is worked on
    logic signed [POS_W-1:0] r_px, r_py, r_pz;

    kerl_cell_conv u_cx (.i_clk(i_clk), .i_pos(r_px), .o_cell(cx));
    kerl_cell_conv u_cy (.i_clk(i_clk), .i_pos(r_py), .o_cell(cy));
    kerl_cell_conv u_cz (.i_clk(i_clk), .i_pos(r_pz), .o_cell(cz));

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++) begin : g_cell
            kerl_cell u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_shift(shift),
                .i_rec  (g == ENTRIES-1 ? feed : chain[(g+1) % ENTRIES]),
                .o_rec  (chain[g])
            );
        end
    endgenerate

    assign head = chain[0];
    // index of head record during scan equals the scan counter
    logic [IW-1:0] idx;
    logic [TIME_W-1:0] age;
    logic match, expire;
    assign idx    = r_cnt[IW-1:0];
    assign age    = r_now - head.last;
    assign match  = head.valid && head.kind == r_kind && head.asset == r_asset &&
                    head.cx == cx && head.cy == cy && head.cz == cz;
    assign expire = head.valid && age > TIME_W'(r_expiry);

    logic accepted;
    logic load_out;
    assign accepted = i_valid && !o_stall;
    assign o_stall  = !i_rst_n || (r_state != S_IDLE);
    assign shift    = (r_state == S_SCAN) || (r_state == S_WB);
    assign load_out = (r_state == S_OUT) && (!r_ovalid || !i_stall);

    // rotation: head goes to tail; sweep updates it in lap one, play in lap two
    always_comb begin
        feed = head;
        if (r_state == S_SCAN) begin
            if (r_op == OP_SWEEP && expire) begin
                feed.valid = 1'b0;
            end
        end else begin
            if (r_op == OP_PLAY && r_hit && idx == r_hit_idx && r_allowed) begin
                feed.last = r_now;
            end else if (r_op == OP_PLAY && !r_hit && r_free && idx == r_free_idx) begin
                feed.valid = 1'b1;
                feed.kind  = r_kind;
                feed.asset = r_asset;
                feed.cx    = cx;
                feed.cy    = cy;
                feed.cz    = cz;
                feed.last  = r_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accepted) begin
            r_op    <= i_operation;
            r_kind  <= i_kind;
            r_asset <= i_asset_id;
            r_now   <= i_now_ms;
            r_iv    <= i_min_interval;
            r_px    <= i_pos_x;
            r_py    <= i_pos_y;
            r_pz    <= i_pos_z;
        end
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_expiry <= 16'd30000;
        end else begin
            if (i_cfg_we) begin
                r_expiry <= i_cfg_wdata;
            end
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accepted) begin
                        r_state   <= S_CONV;
                        r_wait    <= 2'd0;
                        r_hit     <= 1'b0;
                        r_free    <= 1'b0;
                        r_removed <= '0;
                        r_allowed <= 1'b0;
                        r_full    <= 1'b0;
                        r_cnt     <= '0;
                    end
                end
                S_CONV: begin
                    // wait while the position passes through the converter pipeline
                    if (r_wait == 2'd1) begin
                        r_state <= S_SCAN;
                    end else begin
                        r_wait <= r_wait + 2'd1;
                    end
                end
                S_SCAN: begin
                    if (r_op == OP_SWEEP) begin
                        if (expire && r_removed != {CNT_W{1'b1}}) begin
                            r_removed <= r_removed + CNT_W'(1);
                        end
                    end else if (head.valid) begin
                        if (match && !r_hit) begin
                            r_hit     <= 1'b1;
                            r_hit_idx <= idx;
                            r_allowed <= age >= TIME_W'(r_iv);
                        end
                    end else if (!r_free) begin
                        r_free     <= 1'b1;
                        r_free_idx <= idx;
                    end
                    if (r_cnt == CW'(ENTRIES - 1)) begin
                        r_cnt   <= '0;
                        r_state <= (r_op == OP_SWEEP) ? S_OUT : S_WB;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                S_WB: begin
                    // second lap: apply the update at the chosen entry
                    if (r_cnt == '0) begin
                        if (!r_hit) begin
                            r_allowed <= r_free;
                            r_full    <= !r_free;
                        end
                    end
                    if (r_cnt == CW'(ENTRIES - 1)) begin
                        r_state <= S_OUT;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                S_OUT: begin
                    if (load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_allowed <= r_allowed;
            r_out_full    <= r_full;
            r_out_removed <= r_removed;
        end
    end

    assign o_valid         = r_ovalid;
    assign o_allowed       = r_out_allowed;
    assign o_table_full    = r_out_full;
    assign o_removed_count = r_out_removed;
endmodule
`default_nettype wire

/* verif/tb_top.sv */
// Testbench for keyed_event_rate_limiter: random and directed play and sweep
// requests, checked against an in-bench predictor of the record table.
// Depends on kerl_pkg and the keyed_event_rate_limiter RTL.
`default_nettype none
module tb_top;
    import kerl_pkg::*;

    localparam int N_REC = 64;

    typedef struct packed {
        logic                      op;
        logic                      kind;
        logic [ASSET_W-1:0]        asset;
        logic signed [POS_W-1:0]   px;
        logic signed [POS_W-1:0]   py;
        logic signed [POS_W-1:0]   pz;
        logic [TIME_W-1:0]         now;
        logic [IV_W-1:0]           iv;
    } t_req;

    typedef struct packed {
        logic             allowed;
        logic             full;
        logic [CNT_W-1:0] removed;
    } t_verdict;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [15:0] i_cfg_wdata = '0;
    logic i_valid = 1'b0;
    logic o_stall;
    t_req req_q = '0;
    logic o_valid;
    logic i_stall = 1'b1;
    logic o_allowed, o_table_full;
    logic [CNT_W-1:0] o_removed_count;

    always #1 i_clk = ~i_clk;

    keyed_event_rate_limiter u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_operation(req_q.op), .i_kind(req_q.kind), .i_asset_id(req_q.asset),
        .i_pos_x(req_q.px), .i_pos_y(req_q.py), .i_pos_z(req_q.pz),
        .i_now_ms(req_q.now), .i_min_interval(req_q.iv),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_allowed(o_allowed), .o_table_full(o_table_full),
        .o_removed_count(o_removed_count)
    );

    // predictor state
    logic [15:0]       lim_expiry;
    logic              rec_valid [N_REC];
    logic              rec_kind  [N_REC];
    logic [15:0]       rec_asset [N_REC];
    int                rec_cx [N_REC], rec_cy [N_REC], rec_cz [N_REC];
    logic [31:0]       rec_last  [N_REC];

    t_req     pending_reqs[$];
    t_verdict verdicts_due[$];
    int       n_errors = 0;
    bit       stim_done = 0;
    bit       hold_sender = 0;

    function automatic int pos_to_cell(logic signed [POS_W-1:0] p);
        int v;
        v = int'(p) + 50;
        if (v >= 0) return v / 100;
        return -((-v + 99) / 100);
    endfunction

    function automatic t_verdict predict_verdict(t_req r);
        t_verdict res;
        int cx, cy, cz, hit, free_i;
        res = '0;
        cx = pos_to_cell(r.px);
        cy = pos_to_cell(r.py);
        cz = pos_to_cell(r.pz);
        hit = -1;
        free_i = -1;
        if (r.op == OP_SWEEP) begin
            for (int i = 0; i < N_REC; i++)
                if (rec_valid[i] && (r.now - rec_last[i]) > {16'd0, lim_expiry}) begin
                    rec_valid[i] = 1'b0;
                    res.removed++;
                end
            return res;
        end
        for (int i = 0; i < N_REC; i++) begin
            if (rec_valid[i]) begin
                if (hit < 0 && rec_kind[i] == r.kind && rec_asset[i] == r.asset &&
                    rec_cx[i] == cx && rec_cy[i] == cy && rec_cz[i] == cz)
                    hit = i;
            end else if (free_i < 0) begin
                free_i = i;
            end
        end
        if (hit >= 0) begin
            if ((r.now - rec_last[hit]) >= {16'd0, r.iv}) begin
                rec_last[hit] = r.now;
                res.allowed = 1'b1;
            end
        end else if (free_i >= 0) begin
            rec_valid[free_i] = 1'b1;
            rec_kind[free_i] = r.kind;
            rec_asset[free_i] = r.asset;
            rec_cx[free_i] = cx;
            rec_cy[free_i] = cy;
            rec_cz[free_i] = cz;
            rec_last[free_i] = r.now;
            res.allowed = 1'b1;
        end else begin
            res.full = 1'b1;
        end
        return res;
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 80);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 3);
    endfunction

    // driver
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                verdicts_due.push_back(predict_verdict(req_q));
                if (send_gap == 0 && pending_reqs.size() > 0 && !hold_sender) begin
                    req_q <= pending_reqs.pop_front();
                    send_gap <= gap_len();
                end else begin
                    i_valid <= 1'b0;
                end
            end else if (!i_valid) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                end else if (pending_reqs.size() > 0 && !hold_sender) begin
                    req_q <= pending_reqs.pop_front();
                    i_valid <= 1'b1;
                    send_gap <= gap_len();
                end
            end
        end
    end

    // monitor
    int stall_left = 0;
    always @(posedge i_clk) begin
        t_verdict got, want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                got = '{o_allowed, o_table_full, o_removed_count};
                if (verdicts_due.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("unexpected result %p", got);
                end else begin
                    want = verdicts_due.pop_front();
                    if (got !== want) begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display("mismatch: expected %p actual %p", want, got);
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                i_stall <= 1'b1;
            end else if ($urandom_range(0, 3) == 0) begin
                stall_left <= gap_len();
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    function automatic t_req rand_req(int hot_keys, logic [31:0] t);
        t_req r;
        r.op = ($urandom_range(0, 9) == 0) ? OP_SWEEP : OP_PLAY;
        r.kind = 1'($urandom_range(0, 1));
        r.asset = (hot_keys > 0) ? 16'($urandom_range(0, hot_keys - 1)) : 16'($urandom);
        r.px = (hot_keys > 0) ? 24'(int'($urandom_range(0, 400)) - 200) : 24'($urandom);
        r.py = (hot_keys > 0) ? 24'(int'($urandom_range(0, 2)) * 49) : 24'($urandom);
        r.pz = 24'($urandom);
        if (hot_keys > 0) r.pz = 24'(int'($urandom_range(0, 1)) * 150 - 75);
        r.now = t;
        r.iv = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 500));
        return r;
    endfunction

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || i_valid || verdicts_due.size() > 0)
            @(posedge i_clk);
        repeat (N_REC + 10) @(posedge i_clk);
    endtask

    task automatic write_expiry(logic [15:0] v);
        i_cfg_wdata <= v;
        i_cfg_we <= 1'b1;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        lim_expiry = v;
    endtask

    initial begin
        t_req r;
        logic [31:0] t;
        logic [15:0] expiry_set [4];
        lim_expiry = 16'd30000;
        for (int i = 0; i < N_REC; i++) rec_valid[i] = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, rounding edges, repeat within interval, wrap
        r = '0;
        r.px = 24'sh7FFFFF; r.py = 24'sh800000; r.pz = -24'sd50; r.now = 32'hFFFF_FFF0;
        r.iv = 16'hFFFF; r.asset = 16'hFFFF; r.kind = 1'b1;
        pending_reqs.push_back(r);
        r.now = 32'h0000_0010;           // wrapped, still within interval: refuse
        pending_reqs.push_back(r);
        r.pz = -24'sd51;                 // different cell
        pending_reqs.push_back(r);
        r = '0; r.px = 24'sd49; r.now = 32'd100; r.iv = 16'd0;
        pending_reqs.push_back(r);
        r.px = 24'sd50;                  // rounds up to next cell
        pending_reqs.push_back(r);
        r.px = -24'sd149; r.now = 32'd100;
        pending_reqs.push_back(r);
        r.px = 24'sd0; r.now = 32'd100;  // hit, zero interval: allow
        pending_reqs.push_back(r);
        r = '0; r.op = OP_SWEEP; r.now = 32'd30100; r.kind = 1'b1; r.asset = 16'hFFFF;
        pending_reqs.push_back(r);
        r.now = 32'd30101;
        pending_reqs.push_back(r);
        wait_drained();

        // fill the table to force the full flag, then sweep with zero expiry
        write_expiry(16'd0);
        for (int i = 0; i < N_REC + 3; i++) begin
            r = '0; r.asset = 16'(i + 1); r.now = 32'd5000;
            pending_reqs.push_back(r);
        end
        r = '0; r.op = OP_SWEEP; r.now = 32'd5000;
        pending_reqs.push_back(r);
        r.now = 32'd5001;
        pending_reqs.push_back(r);
        wait_drained();

        expiry_set[0] = 16'hFFFF;
        expiry_set[1] = 16'd300;
        expiry_set[2] = 16'd30000;
        expiry_set[3] = 16'd5;
        t = $urandom;
        for (int ph = 0; ph < 4; ph++) begin
            write_expiry(expiry_set[ph]);
            for (int k = 0; k < 120; k++) begin
                t += $urandom_range(0, 200);
                if ($urandom_range(0, 7) == 0) r = rand_req(0, $urandom);
                else r = rand_req(12, t);
                pending_reqs.push_back(r);
                if (k == 60 && ph == 1) begin
                    // hold off until every result in flight is back
                    hold_sender = 1;
                    while (i_valid || verdicts_due.size() > 0)
                        @(posedge i_clk);
                    hold_sender = 0;
                end
            end
            wait_drained();
        end
        stim_done = 1;
    end

    initial begin
        wait (stim_done);
        if (n_errors == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

    initial begin
        #4000000;
        $display("tb: failure");
        $finish;
    end
endmodule
`default_nettype wire

/* sim.f */
rtl/kerl_pkg.sv
rtl/kerl_cell_conv.sv
rtl/kerl_cell.sv
rtl/keyed_event_rate_limiter.sv
verif/tb_top.sv
